### rtl/cpls_pkg.sv
package cpls_pkg;

  // Register map, one 32-bit word per register
  typedef enum logic [2:0] {
    RegPowerLimit   = 3'd0,
    RegTorqueCoef   = 3'd1,
    RegSpeedSqCoef  = 3'd2,
    RegCurrentSqCoef = 3'd3,
    RegStaticPower  = 3'd4,
    RegEffRecip     = 3'd5,
    RegRatioBias    = 3'd6
  } reg_idx_e;

  // Reset values
  localparam logic [7:0]  POWER_LIMIT_RST  = 8'd60;
  localparam logic [31:0] TORQUE_COEF_RST  = 32'd2195637;
  localparam logic [31:0] SPEED_SQ_RST     = 32'd5775735;
  localparam logic [31:0] CURRENT_SQ_RST   = 32'd279276;
  localparam logic [15:0] STATIC_POWER_RST = 16'd1045;
  localparam logic [15:0] EFF_RECIP_RST    = 16'd19275;
  localparam logic [14:0] RATIO_BIAS_RST   = 15'd33;

  // Arithmetic constants
  localparam logic [11:0] LOW_VOLT     = 12'd500;   // hundredths of a volt
  localparam logic [15:0] MARGIN_Q4    = 16'd32;    // 2 W in Q.4
  localparam logic [7:0]  COIL_AMPS_Q4 = 8'd224;    // 14 A in Q.4
  // floor(x/100) = (x * VOLT_RECIP) >> VOLT_SHIFT for x below 2^20
  localparam logic [20:0] VOLT_RECIP   = 21'd1342178;
  localparam int          VOLT_SHIFT   = 27;
  localparam logic [15:0] ONE_Q15      = 16'd32768;
  localparam logic [17:0] EST_MAX      = 18'd262143;

  // Sideband that travels alongside the divider stages
  typedef struct packed {
    logic        valid;
    logic        bypass;     // result known without division
    logic [15:0] bypass_val;
    logic [17:0] est_sat;
  } div_side_t;

endpackage

### rtl/chassis_power_limit_scaler.sv
// Chassis power limit scaler. Takes four motor currents, four rotor speeds
// and the supercapacitor voltage per transfer and returns a Q1.15 current
// scale factor plus the estimated chassis power (Q14.4, saturating). Fully
// pipelined: one transfer accepted every cycle while the output is not
// stalled, passing five stages of wheel power model and allowed power, eight
// divider stages at two quotient bits each and one output register. The whole
// pipeline stalls together while a result waits at the output. Registers
// sit on an APB port at byte addresses 4*i and should be written only
// while no transfer is in flight.
module chassis_power_limit_scaler (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] current_fr_i,
  input  logic signed [15:0] current_fl_i,
  input  logic signed [15:0] current_bl_i,
  input  logic signed [15:0] current_br_i,
  input  logic signed [14:0] rpm_fr_i,
  input  logic signed [14:0] rpm_fl_i,
  input  logic signed [14:0] rpm_bl_i,
  input  logic signed [14:0] rpm_br_i,
  input  logic [11:0]        cap_voltage_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        current_scale_o,
  output logic [17:0]        estimated_power_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [7:0]  power_limit_q;
  logic [31:0] torque_coef_q, speed_sq_q, current_sq_q;
  logic [15:0] static_power_q, eff_recip_q;
  logic [14:0] ratio_bias_q;
  logic        cfg_wr;
  cpls_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cpls_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_limit_q  <= cpls_pkg::POWER_LIMIT_RST;
      torque_coef_q  <= cpls_pkg::TORQUE_COEF_RST;
      speed_sq_q     <= cpls_pkg::SPEED_SQ_RST;
      current_sq_q   <= cpls_pkg::CURRENT_SQ_RST;
      static_power_q <= cpls_pkg::STATIC_POWER_RST;
      eff_recip_q    <= cpls_pkg::EFF_RECIP_RST;
      ratio_bias_q   <= cpls_pkg::RATIO_BIAS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cpls_pkg::RegPowerLimit:    power_limit_q  <= pwdata[7:0];
        cpls_pkg::RegTorqueCoef:    torque_coef_q  <= pwdata;
        cpls_pkg::RegSpeedSqCoef:   speed_sq_q     <= pwdata;
        cpls_pkg::RegCurrentSqCoef: current_sq_q   <= pwdata;
        cpls_pkg::RegStaticPower:   static_power_q <= pwdata[15:0];
        cpls_pkg::RegEffRecip:      eff_recip_q    <= pwdata[15:0];
        cpls_pkg::RegRatioBias:     ratio_bias_q   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (cfg_idx)
      cpls_pkg::RegPowerLimit:    prdata = {24'd0, power_limit_q};
      cpls_pkg::RegTorqueCoef:    prdata = torque_coef_q;
      cpls_pkg::RegSpeedSqCoef:   prdata = speed_sq_q;
      cpls_pkg::RegCurrentSqCoef: prdata = current_sq_q;
      cpls_pkg::RegStaticPower:   prdata = {16'd0, static_power_q};
      cpls_pkg::RegEffRecip:      prdata = {16'd0, eff_recip_q};
      cpls_pkg::RegRatioBias:     prdata = {17'd0, ratio_bias_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: all stages move together
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic [4:0] vld_q;

  // ---------------------------------------------------------------------
  // Stage 1: magnitudes and raw products
  logic [15:0] cur_raw [4];
  logic [14:0] rpm_raw [4];
  logic [15:0] i_mag   [4];
  logic [14:0] r_mag   [4];

  assign cur_raw[0] = current_fr_i;
  assign cur_raw[1] = current_fl_i;
  assign cur_raw[2] = current_bl_i;
  assign cur_raw[3] = current_br_i;
  assign rpm_raw[0] = rpm_fr_i;
  assign rpm_raw[1] = rpm_fl_i;
  assign rpm_raw[2] = rpm_bl_i;
  assign rpm_raw[3] = rpm_br_i;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      i_mag[w] = cur_raw[w][15] ? (~cur_raw[w] + 16'd1) : cur_raw[w];
      r_mag[w] = rpm_raw[w][14] ? (~rpm_raw[w] + 15'd1) : rpm_raw[w];
    end
  end

  logic [29:0] ir_q [4];
  logic [28:0] rr_q [4];
  logic [30:0] ii_q [4];
  logic [19:0] volt_x_q;
  logic        low_volt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < 4; w++) begin
        ir_q[w] <= 30'(i_mag[w] * r_mag[w]);
        rr_q[w] <= 29'(r_mag[w] * r_mag[w]);
        ii_q[w] <= 31'(i_mag[w] * i_mag[w]);
      end
      volt_x_q   <= 20'(cap_voltage_i * cpls_pkg::COIL_AMPS_Q4);
      low_volt_q <= (cap_voltage_i <= cpls_pkg::LOW_VOLT);
    end
  end

  // Stage 2: coefficient products
  logic [61:0] t_q [4];
  logic [60:0] s_q [4];
  logic [62:0] c_q [4];
  logic [40:0] volt_p_q;
  logic        low_volt2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < 4; w++) begin
        t_q[w] <= 62'(torque_coef_q * ir_q[w]);
        s_q[w] <= 61'(speed_sq_q * rr_q[w]);
        c_q[w] <= 63'(current_sq_q * ii_q[w]);
      end
      volt_p_q    <= 41'(volt_x_q * cpls_pkg::VOLT_RECIP);
      low_volt2_q <= low_volt_q;
    end
  end

  // Stage 3: per-wheel sum at scale 2^20, allowed power
  logic [63:0]        wheel  [4];
  logic [43:0]        wsum_q [4];
  logic signed [15:0] allowed_d;
  logic signed [15:0] allowed3_q;
  logic [15:0]        lim_q4;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      wheel[w] = 64'(t_q[w]) + 64'(s_q[w]) + 64'(c_q[w])
               + {16'd0, static_power_q, 32'd0};
    end
    lim_q4 = {4'd0, power_limit_q, 4'd0};
    if (low_volt2_q) begin
      allowed_d = $signed(lim_q4 - cpls_pkg::MARGIN_Q4);
    end else begin
      allowed_d = $signed(lim_q4 + 16'(volt_p_q[40:cpls_pkg::VOLT_SHIFT]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < 4; w++) begin
        wsum_q[w] <= wheel[w][63:20];
      end
      allowed3_q <= allowed_d;
    end
  end

  // Stage 4: total over wheels
  logic [45:0]        total_q;
  logic signed [15:0] allowed4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      total_q    <= 46'(wsum_q[0]) + 46'(wsum_q[1]) + 46'(wsum_q[2]) + 46'(wsum_q[3]);
      allowed4_q <= allowed3_q;
    end
  end

  // Stage 5: efficiency correction
  logic [61:0]        pw_q;
  logic signed [15:0] allowed5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q       <= 62'(total_q * eff_recip_q);
      allowed5_q <= allowed4_q;
    end
  end

  // Stage 6 logic: estimate, special cases, divider entry
  logic [31:0]         est;
  logic [15:0]         allowed_u;
  logic                allowed_pos;
  logic                allowed_over;
  cpls_pkg::div_side_t side_in, side_out;
  logic [15:0]         quo;

  always_comb begin
    est          = pw_q[61:30];
    allowed_u    = allowed5_q;
    allowed_pos  = (allowed5_q > 16'sd0);
    allowed_over = allowed_pos && ({16'd0, allowed_u} > est);
    side_in.valid      = vld_q[4];
    side_in.bypass     = (est == 32'd0) || !allowed_pos || allowed_over;
    side_in.bypass_val = allowed_over ? cpls_pkg::ONE_Q15 : 16'd0;
    side_in.est_sat    = (est > {14'd0, cpls_pkg::EST_MAX}) ? cpls_pkg::EST_MAX
                                                            : est[17:0];
  end

  cpls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_in),
    .num_i  (allowed_u[13:0]),
    .den_i  (est[30:0]),
    .side_o (side_out),
    .quo_o  (quo)
  );

  // Valid chain through the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // Output register: bias and saturation
  logic [15:0] scale_d;
  logic [15:0] scale_q;
  logic [17:0] est_q;

  always_comb begin
    if (side_out.bypass) begin
      scale_d = side_out.bypass_val;
    end else if (quo > {1'b0, ratio_bias_q}) begin
      scale_d = quo - {1'b0, ratio_bias_q};
    end else begin
      scale_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scale_q <= scale_d;
      est_q   <= side_out.est_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_scale_o   = scale_q;
  assign estimated_power_o = est_q;

  // ---------------------------------------------------------------------
  // Assertions
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> current_scale_o <= cpls_pkg::ONE_Q15)
    else $error("scale above one");

  a_zero_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && estimated_power_o == 18'd0) |->
      (current_scale_o == 16'd0 || current_scale_o == cpls_pkg::ONE_Q15))
    else $error("zero estimate must give zero or full scale");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(side_out.valid))
    else $error("pipeline moved during stall");

endmodule

### rtl/cpls_div.sv
// Pipelined restoring divider: quo = floor(num * 2^15 / den), num <= den.
// Two quotient bits per stage, eight stages.
module cpls_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cpls_pkg::div_side_t  side_i,
  input  logic [13:0]          num_i,
  input  logic [30:0]          den_i,
  output cpls_pkg::div_side_t  side_o,
  output logic [15:0]          quo_o
);

  localparam int NumStages = 8;

  logic [NumStages-1:0] vld_q;
  logic [31:0]         rem_q  [NumStages];
  logic [30:0]         den_q  [NumStages];
  logic [15:0]         quo_q  [NumStages];
  cpls_pkg::div_side_t side_q [NumStages];

  logic [31:0] rem_in [NumStages];
  logic [30:0] den_in [NumStages];
  logic [15:0] quo_in [NumStages];
  logic [31:0] rem_d  [NumStages];
  logic [15:0] quo_d  [NumStages];

  // Stage operands; the first stage takes the new division
  always_comb begin
    rem_in[0] = {18'd0, num_i};
    den_in[0] = den_i;
    quo_in[0] = '0;
    for (int s = 1; s < NumStages; s++) begin
      rem_in[s] = rem_q[s-1];
      den_in[s] = den_q[s-1];
      quo_in[s] = quo_q[s-1];
    end
  end

  // Two divide steps per stage; the very first step has no shift
  always_comb begin
    logic [31:0] r;
    logic [15:0] q;
    for (int s = 0; s < NumStages; s++) begin
      r = rem_in[s];
      q = quo_in[s];
      for (int b = 0; b < 2; b++) begin
        if (!(s == 0 && b == 0)) begin
          r = {r[30:0], 1'b0};
        end
        if (r >= {1'b0, den_in[s]}) begin
          r = r - {1'b0, den_in[s]};
          q = {q[14:0], 1'b1};
        end else begin
          q = {q[14:0], 1'b0};
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end
  end

  // Valid bits, the only reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStages-2:0], side_i.valid};
    end
  end

  // Stage data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < NumStages; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < NumStages; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_in[s];
      end
    end
  end

  always_comb begin
    side_o       = side_q[NumStages-1];
    side_o.valid = vld_q[NumStages-1];
  end

  assign quo_o = quo_q[NumStages-1];

endmodule
